// ===== hw/rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the control-change mapper
// Register indexes, message codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 10;
    localparam int DIVR_W          = 10;
    localparam int CC_W            = 7;
    localparam int CH_W            = 5;
    localparam int OUT_TDATA_W     = 24;

    localparam logic [CC_W-1:0]       SWITCH_CC  = 7'd12;
    localparam logic [CC_W-1:0]       CC_ON      = 7'd127;
    localparam logic [CC_W-1:0]       CC_OFF     = 7'd0;
    localparam logic [CFG_DATA_W-1:0] IN_HI_RST  = 10'd1023;
    localparam logic [CC_W-1:0]       OUT_HI_RST = 7'd127;
    localparam logic [CH_W-1:0]       CH_RST     = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_LO   = 3'd0,
        CFG_IN_HI   = 3'd1,
        CFG_OUT_LO  = 3'd2,
        CFG_OUT_HI  = 3'd3,
        CFG_SW_MODE = 3'd4,
        CFG_CTRL_NO = 3'd5,
        CFG_MIDI_CH = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PICK,
        ST_IVL,
        ST_MODGO,
        ST_MOD,
        ST_MAP,
        ST_CHK,
        ST_EMIT_A,
        ST_EMIT_B
    } t_state;

    typedef enum logic [1:0] {
        DIV_IVL,
        DIV_MOD,
        DIV_MAP
    } t_div_op;

    typedef enum logic {
        CAND_SNAP,
        CAND_MAP
    } t_cand_src;

    typedef enum logic {
        MSG_FIRST,
        MSG_SECOND
    } t_msg_sel;

    typedef struct packed {
        logic      smp_load;
        logic      cand_load;
        t_cand_src cand_src;
        logic      div_start;
        t_div_op   div_op;
        logic      ivl_one;
        logic      ivl_div;
        logic      out_load;
        t_msg_sel  msg_sel;
        logic      commit;
    } t_cmd;

    typedef struct packed {
        logic snap;
        logic ivl_dirty;
        logic ivl_need_div;
        logic div_done;
        logic rem_zero;
        logic ispan_zero;
        logic map_eq_last;
        logic two_msgs;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/pcc_div.sv =====
// ----------------------------------------------------------------------------
// pcc_div: shared restoring divider
// One quotient bit per cycle; the dividend comes in left aligned so that
// the step count sets the quotient width. Quotient and remainder hold
// until the next start.
// ----------------------------------------------------------------------------
module pcc_div
    import pcc_pkg::*;
#(
    parameter int DW = SAMPLE_BITS_DEF + 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_dividend,
    input  logic [DIVR_W-1:0]        i_divisor,
    input  logic [$clog2(DW+1)-1:0]  i_steps,
    output logic                     o_done,
    output logic [DW-1:0]            o_quot,
    output logic [DIVR_W-1:0]        o_rem
);

    logic                    r_busy;
    logic                    r_done;
    logic [$clog2(DW+1)-1:0] r_cnt;
    logic [DW-1:0]           r_q;
    logic [DIVR_W-1:0]       r_r;
    logic [DIVR_W-1:0]       r_d;
    logic [DIVR_W:0]         w_trial;
    logic [DIVR_W:0]         w_diff;
    logic                    w_ge;

    assign w_trial = {r_r, r_q[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], w_ge};
            r_r <= w_ge ? w_diff[DIVR_W-1:0] : w_trial[DIVR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== hw/rtl/pcc_dp.sv =====
// ----------------------------------------------------------------------------
// pcc_dp: datapath of the control-change mapper
// Configuration registers, sample and candidate registers, interval and
// linear map arithmetic around the shared divider, and the output register.
// ----------------------------------------------------------------------------
module pcc_dp
    import pcc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [CC_W-1:0]        o_cc_number,
    output logic [CC_W-1:0]        o_cc_value,
    output logic [CH_W-1:0]        o_channel,
    output logic                   o_last
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 7;
    localparam int SW = $clog2(DW + 1);
    localparam logic [SB+CFG_DATA_W-1:0] IN_HI_EXT = {{SB{1'b0}}, IN_HI_RST};

    logic [SB-1:0]     r_in_lo;
    logic [SB-1:0]     r_in_hi;
    logic [CC_W-1:0]   r_out_lo;
    logic [CC_W-1:0]   r_out_hi;
    logic              r_sw_mode;
    logic [CC_W-1:0]   r_ctrl_no;
    logic [CH_W-1:0]   r_midi_ch;
    logic              r_dirty;
    logic [DIVR_W-1:0] r_interval;
    logic [CC_W-1:0]   r_last;
    logic [SB-1:0]     r_sample;
    logic [CC_W-1:0]   r_cand;
    logic              r_map_neg;
    logic              r_out_valid;
    logic [CC_W-1:0]   r_out_num;
    logic [CC_W-1:0]   r_out_val;
    logic [CH_W-1:0]   r_out_ch;
    logic              r_out_last;

    logic [SB+CFG_DATA_W-1:0] w_cfg_ext;
    logic signed [SB:0]       w_ispan;
    logic                     w_ispan_neg;
    logic                     w_ispan_zero;
    logic [SB:0]              w_ispan_mag;
    logic [SB+DIVR_W:0]       w_imag_ext;
    logic [DIVR_W-1:0]        w_ispan_m10;
    logic                     w_rev;
    logic [CC_W-1:0]          w_ospan_mag;
    logic [CC_W-1:0]          w_lo;
    logic [CC_W-1:0]          w_hi;
    logic signed [SB:0]       w_sdiff;
    logic signed [CC_W:0]     w_ospan_s;
    logic signed [SB+8:0]     w_num;
    logic [SB+8:0]            w_num_mag;
    logic                     w_snap_hi;
    logic                     w_snap_lo;
    logic [CC_W-1:0]          w_snap_val;
    logic signed [DW+1:0]     w_qs;
    logic signed [DW+1:0]     w_v;
    logic signed [DW+1:0]     w_lo_s;
    logic signed [DW+1:0]     w_hi_s;
    logic [CC_W-1:0]          w_map_val;
    logic                     w_sw_on;
    logic                     w_sw_off;
    logic [DW-1:0]            w_div_dvd;
    logic [DIVR_W-1:0]        w_div_dvs;
    logic [SW-1:0]            w_div_steps;
    logic                     w_div_done;
    logic [DW-1:0]            w_quot;
    logic [DIVR_W-1:0]        w_rem;
    logic [CC_W-1:0]          w_msg_num;
    logic [CC_W-1:0]          w_msg_val;
    logic                     w_msg_last;

    assign w_cfg_ext = {{SB{1'b0}}, i_cfg_wdata};

    // Configuration and derived-state dirty flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_lo   <= '0;
            r_in_hi   <= IN_HI_EXT[SB-1:0];
            r_out_lo  <= '0;
            r_out_hi  <= OUT_HI_RST;
            r_sw_mode <= 1'b0;
            r_ctrl_no <= '0;
            r_midi_ch <= CH_RST;
            r_dirty   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_LO: begin
                    r_in_lo <= w_cfg_ext[SB-1:0];
                    r_dirty <= 1'b1;
                end
                CFG_IN_HI: begin
                    r_in_hi <= w_cfg_ext[SB-1:0];
                    r_dirty <= 1'b1;
                end
                CFG_OUT_LO: begin
                    r_out_lo <= i_cfg_wdata[CC_W-1:0];
                    r_dirty  <= 1'b1;
                end
                CFG_OUT_HI: begin
                    r_out_hi <= i_cfg_wdata[CC_W-1:0];
                    r_dirty  <= 1'b1;
                end
                CFG_SW_MODE: r_sw_mode <= i_cfg_wdata[0];
                CFG_CTRL_NO: r_ctrl_no <= i_cfg_wdata[CC_W-1:0];
                CFG_MIDI_CH: r_midi_ch <= i_cfg_wdata[CH_W-1:0];
                default: ;
            endcase
        end else if (i_cmd.ivl_one || i_cmd.ivl_div) begin
            r_dirty <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_cmd.commit) begin
            r_last <= r_cand;
        end
    end

    // Spans
    assign w_ispan      = $signed({1'b0, r_in_hi}) - $signed({1'b0, r_in_lo});
    assign w_ispan_neg  = w_ispan[SB];
    assign w_ispan_zero = (w_ispan == '0);
    assign w_ispan_mag  = w_ispan_neg ? -w_ispan : w_ispan;
    assign w_imag_ext   = {{DIVR_W{1'b0}}, w_ispan_mag};
    assign w_ispan_m10  = w_imag_ext[DIVR_W-1:0];
    assign w_rev        = r_out_lo > r_out_hi;
    assign w_ospan_mag  = w_rev ? r_out_lo - r_out_hi : r_out_hi - r_out_lo;
    assign w_lo         = w_rev ? r_out_hi : r_out_lo;
    assign w_hi         = w_rev ? r_out_lo : r_out_hi;

    // Linear map numerator
    assign w_sdiff   = $signed({1'b0, r_sample}) - $signed({1'b0, r_in_lo});
    assign w_ospan_s = $signed({1'b0, r_out_hi}) - $signed({1'b0, r_out_lo});
    assign w_num     = w_sdiff * w_ospan_s;
    assign w_num_mag = w_num[SB+8] ? -w_num : w_num;

    // Snap to output limits
    assign w_snap_hi  = (r_sample >= r_in_hi) && (r_last != r_out_hi);
    assign w_snap_lo  = (r_sample <= r_in_lo) && (r_last != r_out_lo);
    assign w_snap_val = w_snap_hi ? r_out_hi : r_out_lo;

    // Mapped value and clamp
    assign w_qs   = r_map_neg ? -$signed({2'b00, w_quot}) : $signed({2'b00, w_quot});
    assign w_lo_s = $signed({{(DW-5){1'b0}}, w_lo});
    assign w_hi_s = $signed({{(DW-5){1'b0}}, w_hi});
    assign w_v    = w_ispan_zero ? $signed({{(DW-5){1'b0}}, r_out_lo})
                                 : w_qs + $signed({{(DW-5){1'b0}}, r_out_lo});

    always_comb begin
        if (w_v < w_lo_s) begin
            w_map_val = w_lo;
        end else if (w_v > w_hi_s) begin
            w_map_val = w_hi;
        end else begin
            w_map_val = w_v[CC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.cand_load) begin
            r_cand <= (i_cmd.cand_src == CAND_SNAP) ? w_snap_val : w_map_val;
        end
        if (i_cmd.div_start && i_cmd.div_op == DIV_MAP) begin
            r_map_neg <= w_num[SB+8] ^ w_ispan_neg;
        end
        if (i_cmd.ivl_one) begin
            r_interval <= DIVR_W'(1);
        end else if (i_cmd.ivl_div) begin
            r_interval <= (w_quot[DIVR_W-1:0] == '0) ? DIVR_W'(1) : w_quot[DIVR_W-1:0];
        end
    end

    // Divider operands
    always_comb begin
        unique case (i_cmd.div_op)
            DIV_IVL: begin
                w_div_dvd   = {w_ispan_m10, {(DW-DIVR_W){1'b0}}};
                w_div_dvs   = {{(DIVR_W-CC_W){1'b0}}, w_ospan_mag};
                w_div_steps = SW'(DIVR_W);
            end
            DIV_MOD: begin
                w_div_dvd   = {r_sample, 7'b0};
                w_div_dvs   = r_interval;
                w_div_steps = SW'(SB);
            end
            DIV_MAP: begin
                w_div_dvd   = w_num_mag[DW-1:0];
                w_div_dvs   = w_ispan_m10;
                w_div_steps = SW'(DW);
            end
            default: begin
                w_div_dvd   = '0;
                w_div_dvs   = '0;
                w_div_steps = '0;
            end
        endcase
    end

    pcc_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .i_steps    (w_div_steps),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Message selection
    assign w_sw_on  = r_sw_mode && (r_cand > r_out_lo) && (r_last == r_out_lo);
    assign w_sw_off = r_sw_mode && (r_cand == r_out_lo) && (r_last > r_out_lo);

    always_comb begin
        if (i_cmd.msg_sel == MSG_FIRST) begin
            w_msg_num  = w_sw_on ? SWITCH_CC : r_ctrl_no;
            w_msg_val  = w_sw_on ? CC_ON : r_cand;
            w_msg_last = !(w_sw_on || w_sw_off);
        end else begin
            w_msg_num  = w_sw_on ? r_ctrl_no : SWITCH_CC;
            w_msg_val  = w_sw_on ? r_cand : CC_OFF;
            w_msg_last = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_num  <= w_msg_num;
            r_out_val  <= w_msg_val;
            r_out_ch   <= r_midi_ch;
            r_out_last <= w_msg_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cc_number = r_out_num;
    assign o_cc_value  = r_out_val;
    assign o_channel   = r_out_ch;
    assign o_last      = r_out_last;

    assign o_stat.snap         = w_snap_hi || w_snap_lo;
    assign o_stat.ivl_dirty    = r_dirty;
    assign o_stat.ivl_need_div = !w_ispan_neg && !w_ispan_zero && (w_ospan_mag != '0);
    assign o_stat.div_done     = w_div_done;
    assign o_stat.rem_zero     = (w_rem == '0);
    assign o_stat.ispan_zero   = w_ispan_zero;
    assign o_stat.map_eq_last  = (w_map_val == r_last);
    assign o_stat.two_msgs     = w_sw_on || w_sw_off;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

endmodule

// ===== hw/rtl/pcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcc_ctrl: controller of the control-change mapper
// Sequences snap check, interval refresh, modulo test, linear map and the
// one or two messages that a sample may send.
// ----------------------------------------------------------------------------
module pcc_ctrl
    import pcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.smp_load = 1'b1;
                    n_state        = ST_PICK;
                end
            end
            ST_PICK: begin
                if (i_stat.snap) begin
                    o_cmd.cand_load = 1'b1;
                    o_cmd.cand_src  = CAND_SNAP;
                    n_state         = ST_EMIT_A;
                end else if (i_stat.ivl_dirty && i_stat.ivl_need_div) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_IVL;
                    n_state         = ST_IVL;
                end else begin
                    o_cmd.ivl_one = i_stat.ivl_dirty;
                    n_state       = ST_MODGO;
                end
            end
            ST_IVL: begin
                if (i_stat.div_done) begin
                    o_cmd.ivl_div = 1'b1;
                    n_state       = ST_MODGO;
                end
            end
            ST_MODGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_MOD;
                n_state         = ST_MOD;
            end
            ST_MOD: begin
                if (i_stat.div_done) begin
                    if (!i_stat.rem_zero) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.ispan_zero) begin
                        n_state = ST_CHK;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_op    = DIV_MAP;
                        n_state         = ST_MAP;
                    end
                end
            end
            ST_MAP: begin
                if (i_stat.div_done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.map_eq_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.cand_load = 1'b1;
                    o_cmd.cand_src  = CAND_MAP;
                    n_state         = ST_EMIT_A;
                end
            end
            ST_EMIT_A: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.msg_sel  = MSG_FIRST;
                    if (i_stat.two_msgs) begin
                        n_state = ST_EMIT_B;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_EMIT_B: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.msg_sel  = MSG_SECOND;
                    o_cmd.commit   = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pot_to_control_change_mapper.sv =====
// A snapped sample passes the sample register and the PICK and EMIT_A states to
// reach the output register; any other sample runs the modulo division and, if
// needed, the map division, the first after reset or a limit register write
// also an interval refresh. A new sample is taken only in IDLE, after the last
// one is done; the shared one-bit-per-cycle divider serves interval, modulo and
// map. Reset: synchronous, active low; registers to defaults, last 0.
// ----------------------------------------------------------------------------
// pot_to_control_change_mapper: potentiometer sample to control-change
// Maps ADC samples that snap or pass the interval test onto a controller value
// and sends it on a change, with optional on/off messages on controller 12.
// ----------------------------------------------------------------------------
module pot_to_control_change_mapper
    import pcc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]               i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // cc_number, cc_value, channel
    output logic [OUT_TDATA_W-1:0]              o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    t_cmd            w_cmd;
    t_stat           w_stat;
    logic [CC_W-1:0] w_cc_number;
    logic [CC_W-1:0] w_cc_value;
    logic [CH_W-1:0] w_channel;

    pcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pcc_dp #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cc_number (w_cc_number),
        .o_cc_value  (w_cc_value),
        .o_channel   (w_channel),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-2*CC_W-CH_W){1'b0}},
                             w_channel, w_cc_value, w_cc_number};

endmodule

// ===== hw/rtl/pcc_chk.sv =====
// ----------------------------------------------------------------------------
// pcc_chk: port-level checks of the control-change mapper
// Reset state, one sample at a time, and output hold under stall.
// ----------------------------------------------------------------------------
module pcc_chk
    import pcc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   o_s_axis_tready,
    input  logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   o_m_axis_tlast
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("outputs not idle after reset");

    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second sample taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        ($stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output changed under stall");

endmodule

bind pot_to_control_change_mapper pcc_chk u_pcc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
